### src/ffeg_pkg.sv
// Package with shared widths, action codes and the register index codes of the gap finder.
`default_nettype none
package ffeg_pkg;
  localparam int unsigned OFF_W = 31;
  localparam int unsigned RES_W = 32;
  localparam int unsigned CNT_IN_W = 9;
  localparam int unsigned EIDX_W = 8;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FIND  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_HIGH  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES    = 1'b1;

  typedef logic [OFF_W-1:0] off_t;
  typedef logic [RES_W-1:0] res_t;
endpackage
`default_nettype wire

### src/ffeg_ifs.sv
// Channel interfaces for requests, results and configuration writes.
`default_nettype none
interface ffeg_req_if;
  import ffeg_pkg::*;
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [EIDX_W-1:0] entry_index;
  off_t              entry_offset;
  off_t              entry_size;
  off_t              request_size;
  modport source (output valid, action, entry_index, entry_offset, entry_size,
                  request_size, input ready);
  modport sink (input valid, action, entry_index, entry_offset, entry_size,
                request_size, output ready);
endinterface

interface ffeg_rsp_if;
  import ffeg_pkg::*;
  logic valid;
  logic ready;
  res_t result_offset;
  modport source (output valid, result_offset, input ready);
  modport sink (input valid, result_offset, output ready);
endinterface

interface ffeg_cfg_if;
  import ffeg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  off_t                 data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### src/ffeg_table.sv
// Extent table memory: one write port and one registered read port.
`default_nettype none
module ffeg_table
  import ffeg_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire off_t             wr_start,
  input  wire off_t             wr_length,
  input  wire logic [IDX_W-1:0] rd_addr,
  output      off_t             rd_start,
  output      off_t             rd_length
);
  off_t mem_start [DEPTH];
  off_t mem_length [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr]  <= wr_start;
      mem_length[wr_addr] <= wr_length;
    end
    rd_start  <= mem_start[rd_addr];
    rd_length <= mem_length[rd_addr];
  end
endmodule
`default_nettype wire

### src/first_fit_extent_gap_finder.sv
// Top level of the first-fit extent gap finder.
// A write or unknown action answers in the cycle after its beat is accepted.
// A high action makes one pass over n = min(entries_in_use, TABLE_DEPTH) table entries.
// A find action makes one such pass per visited extent plus a closing pass, each
// pass using one table read port and one selection comparator.
// Synchronous active-high reset clears control and config registers, not the table.
`default_nettype none
module first_fit_extent_gap_finder
  import ffeg_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input wire logic clk,
  input wire logic rst,
  ffeg_cfg_if.sink   cfg,
  ffeg_req_if.sink   req,
  ffeg_rsp_if.source rsp
);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned DIFF_W = RES_W + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;

  logic [1:0]          state;
  off_t                data_start;
  logic [CNT_IN_W-1:0] entries;
  logic                is_high;
  logic [CNT_W-1:0]    cnt;
  logic                pend;
  logic [IDX_W-1:0]    pend_idx;
  logic                first;
  logic                found;
  off_t                best_start;
  off_t                best_length;
  logic [IDX_W-1:0]    best_idx;
  off_t                prev_start;
  logic [IDX_W-1:0]    prev_idx;
  res_t                last_end;
  res_t                high_best;
  off_t                want;
  logic                out_valid;
  res_t                out_data;

  off_t             rd_start;
  off_t             rd_length;
  logic [CNT_W-1:0] n_active;
  logic             req_fire;
  logic             wr_en;
  logic             occupied;
  logic             after_prev;
  logic             better;
  logic             scan_end;
  res_t             cand_end;
  logic signed [DIFF_W-1:0] gap;
  logic                     gap_fits;

  // Handshakes.
  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE) && !out_valid;
  assign req_fire  = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.result_offset = out_data;

  // Active entry count, saturated to the table depth.
  always_comb begin
    if (32'(entries) > TABLE_DEPTH) begin
      n_active = CNT_W'(TABLE_DEPTH);
    end else begin
      n_active = CNT_W'(entries);
    end
  end

  assign wr_en = req_fire && (req.action == ACT_WRITE)
                 && (32'(req.entry_index) < TABLE_DEPTH);

  ffeg_table #(.DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_table (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (IDX_W'(req.entry_index)),
    .wr_start  (req.entry_offset),
    .wr_length (req.entry_size),
    .rd_addr   (cnt[IDX_W-1:0]),
    .rd_start  (rd_start),
    .rd_length (rd_length)
  );

  // Shared compare logic for the entry being evaluated, the scan end and the gap check.
  assign occupied   = (rd_start != '0) && (rd_length != '0);
  assign after_prev = first || (rd_start > prev_start)
                      || ((rd_start == prev_start) && (pend_idx > prev_idx));
  assign better     = !found || (rd_start < best_start);
  assign cand_end   = RES_W'(rd_start) + RES_W'(rd_length);
  assign scan_end   = (cnt == n_active) && !pend;
  assign gap      = $signed({3'b000, best_start}) - $signed({2'b00, last_end});
  assign gap_fits = gap >= $signed({3'b000, want});

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      data_start <= '0;
      entries    <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_DATA_START: data_start <= cfg.data;
        REG_ENTRIES:    entries    <= cfg.data[CNT_IN_W-1:0];
        default:        ;
      endcase
    end
  end

  // Sequencer: one table read per cycle while scanning, one candidate compare per entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
      first     <= 1'b1;
      found     <= 1'b0;
      is_high   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            cnt       <= '0;
            pend      <= 1'b0;
            first     <= 1'b1;
            found     <= 1'b0;
            high_best <= '0;
            last_end  <= RES_W'(data_start);
            want      <= req.request_size;
            if (req.action == ACT_FIND) begin
              is_high <= 1'b0;
              state   <= S_SCAN;
            end else if (req.action == ACT_HIGH) begin
              is_high <= 1'b1;
              state   <= S_SCAN;
            end else begin
              out_data  <= '0;
              out_valid <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          // Issue the next read.
          if (cnt != n_active) begin
            pend     <= 1'b1;
            pend_idx <= cnt[IDX_W-1:0];
            cnt      <= cnt + 1'b1;
          end else begin
            pend <= 1'b0;
          end
          // Evaluate the entry whose data just came back.
          if (pend) begin
            if (is_high) begin
              if ((rd_length != '0) && (cand_end >= high_best)) begin
                high_best <= cand_end;
              end
            end else if (occupied && after_prev && better) begin
              found       <= 1'b1;
              best_start  <= rd_start;
              best_length <= rd_length;
              best_idx    <= pend_idx;
            end
          end
          if (scan_end) begin
            if (is_high) begin
              out_data  <= high_best;
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (!found || gap_fits) begin
            out_data  <= last_end;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            last_end   <= RES_W'(best_start) + RES_W'(best_length);
            prev_start <= best_start;
            prev_idx   <= best_idx;
            first      <= 1'b0;
            found      <= 1'b0;
            cnt        <= '0;
            state      <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A read in flight only exists during a scan.
  assert property (@(posedge clk) disable iff (rst) pend |-> (state == S_SCAN))
    else $error("read in flight outside a scan");

  // A pending result only exists while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (state == S_IDLE))
    else $error("result pending while busy");

  // An accepted beat leaves the block busy or with a result pending.
  assert property (@(posedge clk) disable iff (rst)
    req_fire |=> ((state != S_IDLE) || out_valid))
    else $error("accepted beat dropped");
endmodule
`default_nettype wire
